// ===== design/sigma_truncation_fitness_scaler_defines.svh =====
// Assertion macros shared by the sigma truncation fitness scaler.
// Included by the top level; depends on nothing else.
`ifndef SIGMA_TRUNCATION_FITNESS_SCALER_DEFINES_SVH
`define SIGMA_TRUNCATION_FITNESS_SCALER_DEFINES_SVH

// Same-cycle implication check.
`define STF_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stf: same-cycle check failed");

// Next-cycle implication check.
`define STF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stf: next-cycle check failed");

`endif

// ===== design/stf_pkg.sv =====
// Shared types and constants of the sigma truncation fitness scaler.
// No dependencies; used by the top level, stf_div and stf_sqrt.
package stf_pkg;

   localparam int DATA_W    = 32;
   localparam int SUM_W     = 40;
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = 7;
   localparam int ROOT_W    = 32;
   localparam int SQRT_CNT_W = 5;
   localparam int CSR_W     = 16;
   localparam logic [CSR_W-1:0] SIGMA_RESET = 16'd8192;

   typedef struct packed {
      logic signed [DATA_W-1:0] fitness;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic [30:0] scaled_fitness;
      logic [5:0]  member_index;
      logic        last_out;
   } rsp_type;

endpackage

// ===== design/sigma_truncation_fitness_scaler.sv =====
// Top level of the sigma truncation fitness scaler.
// Depends on stf_pkg, stf_ram, stf_div, stf_sqrt and the assertion macro header.
//
// Usage. Fitness values (signed Q16.16) arrive on req_payload as command
// transactions: one is taken at each clock edge with start high and busy
// low. While loading, busy stays low, so one value per cycle is stored in the
// fitness RAM and added to a running sum. Values beyond MAX_POPULATION are
// dropped. The transaction with is_last set ends the population and raises
// busy for the whole statistics and emit phase.
// For a population of more than one member, after the last value is taken the
// shared serial divider forms the mean, then the variance pass steps through each
// member in turn (RAM read, deviation, three 16x16 partial products on one
// multiplier, two accumulates), then come the variance division, the square
// root and the scale step. Results then leave at one per cycle, in load order,
// on rsp_payload marked by rsp_valid for a single cycle each; the RAM read
// port sets that pace, and the last result follows the end of the emit pass
// through the pending-read and output registers. A population of one skips
// the statistics. The receiver cannot stall; results are never held. The user
// must write the sigma multiplier on the csr channel only while the block is
// idle; the block itself does not enforce this. Reset is synchronous and
// empties the population, restores the multiplier to 2.0 and leaves the RAM
// contents as they are; no clearing pass is needed.
`include "sigma_truncation_fitness_scaler_defines.svh"

module sigma_truncation_fitness_scaler #(
   parameter int MAX_POPULATION = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  stf_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   output stf_pkg::rsp_type            rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [stf_pkg::CSR_W-1:0]   csr_data
);

   localparam int AW = $clog2(MAX_POPULATION);
   localparam int CW = $clog2(MAX_POPULATION + 1);
   localparam int DW = stf_pkg::DATA_W;
   localparam int SW = stf_pkg::SUM_W;

   // Sequencer states, one-hot.
   typedef enum logic [12:0] {
      ST_LOAD = 13'b0000000000001,
      ST_MEAN = 13'b0000000000010,
      ST_VRD  = 13'b0000000000100,
      ST_VD   = 13'b0000000001000,
      ST_VM0  = 13'b0000000010000,
      ST_VM1  = 13'b0000000100000,
      ST_VM2  = 13'b0000001000000,
      ST_VA1  = 13'b0000010000000,
      ST_VA2  = 13'b0000100000000,
      ST_VDIV = 13'b0001000000000,
      ST_SQRT = 13'b0010000000000,
      ST_SCL  = 13'b0100000000000,
      ST_EMIT = 13'b1000000000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in, n_ff, n_in;
   logic signed [SW-1:0]      sum_ff, sum_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [stf_pkg::CSR_W-1:0] sigma_ff, sigma_in;
   logic                      neg_ff, neg_in;
   logic signed [DW:0]        mean_ff, mean_in;
   logic [DW-1:0]             mag_ff, mag_in;
   logic [DW-1:0]             prod_ff, prod_in;
   logic [63:0]               sq_ff, sq_in, ss_ff, ss_in;
   logic [47:0]               csp_ff, csp_in;
   logic signed [41:0]        offset_ff, offset_in;
   logic                      offs_go_ff, offs_go_in;
   logic                      pend_ff, pend_in, pend_last_ff, pend_last_in;
   logic [AW-1:0]             pend_idx_ff, pend_idx_in;
   logic                      rsp_valid_ff;
   stf_pkg::rsp_type          rsp_ff, rsp_in;

   // Load-side signals.
   logic                      accept, store_en, div_dvd_sel;
   logic signed [SW-1:0]      sum_next;
   logic [CW-1:0]             n_next, n_last;
   logic [SW-1:0]             sum_mag;

   // Shared units.
   logic                        div_start, div_done, sqrt_start, sqrt_done;
   logic [stf_pkg::DIV_W-1:0]   div_dvd, div_quo;
   logic [CW-1:0]               div_dvs, div_rem;
   logic [stf_pkg::ROOT_W-1:0]  root;
   logic [15:0]                 mul_a, mul_b;
   logic                        ram_we;
   logic [AW-1:0]               ram_raddr;
   logic [DW-1:0]               ram_rdata;
   logic signed [DW+1:0]        dev;
   logic signed [41:0]          fdiff;
   logic [DW:0]                 q_mean;

   assign accept   = start && (state_ff == ST_LOAD);
   assign store_en = accept && (cnt_ff < CW'(MAX_POPULATION));
   assign sum_next = store_en ? sum_ff + SW'(req_payload.fitness) : sum_ff;
   assign n_next   = store_en ? cnt_ff + 1'b1 : cnt_ff;
   assign n_last   = n_ff - 1'b1;
   assign sum_mag  = sum_next[SW-1] ? SW'(-sum_next) : sum_next;
   assign ram_we   = store_en;
   assign ram_raddr = idx_ff;

   // The divider serves the mean (sum by count) and the variance
   // (squared deviations by count minus one). The variance division starts
   // in the cycle that adds the last square, so it takes the updated total.
   assign div_dvd_sel = (state_ff == ST_LOAD);
   assign div_dvd = div_dvd_sel ? stf_pkg::DIV_W'(sum_mag) : ss_in;
   assign div_dvs = div_dvd_sel ? n_next : n_last;
   assign div_start = (accept && req_payload.is_last && (n_next != '0) && (n_next != CW'(1)))
                      || (state_ff == ST_VA2 && CW'(idx_ff) == n_last);
   assign sqrt_start = (state_ff == ST_VDIV) && div_done;

   assign dev    = (DW+2)'(signed'(ram_rdata)) - (DW+2)'(mean_ff);
   assign fdiff  = 42'(signed'(ram_rdata)) - offset_ff;
   assign q_mean = div_quo[DW:0] + DW'(1'b0);

   // Multiplier operand selection for the three partial products of the
   // squared deviation: high*high, high*low, low*low.
   always_comb begin
      unique case (state_ff)
         ST_VM0:  begin mul_a = mag_ff[31:16]; mul_b = mag_ff[31:16]; end
         ST_VM1:  begin mul_a = mag_ff[31:16]; mul_b = mag_ff[15:0];  end
         default: begin mul_a = mag_ff[15:0];  mul_b = mag_ff[15:0];  end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      sigma_in     = sigma_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      mag_in       = mag_ff;
      prod_in      = DW'(mul_a * mul_b);
      sq_in        = sq_ff;
      ss_in        = ss_ff;
      csp_in       = csp_ff;
      offset_in    = offset_ff;
      offs_go_in   = 1'b0;
      pend_in      = 1'b0;
      pend_idx_in  = idx_ff;
      pend_last_in = 1'b0;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         sigma_in = csr_data;
      end

      // Output stage: one registered result per pending RAM read.
      if (pend_ff) begin
         rsp_in.member_index = 6'(pend_idx_ff);
         rsp_in.last_out     = pend_last_ff;
         if (fdiff < 0) begin
            rsp_in.scaled_fitness = '0;
         end else if (fdiff[41:31] != '0) begin
            rsp_in.scaled_fitness = '1;
         end else begin
            rsp_in.scaled_fitness = fdiff[30:0];
         end
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               sum_in = sum_next;
               cnt_in = n_next;
               if (req_payload.is_last) begin
                  cnt_in = '0;
                  sum_in = '0;
                  n_in   = n_next;
                  neg_in = sum_next[SW-1];
                  if (n_next == CW'(1)) begin
                     // A single member has zero spread; its mean is itself.
                     mean_in  = (DW+1)'(sum_next);
                     csp_in   = '0;
                     state_in = ST_SCL;
                  end else if (n_next != '0) begin
                     state_in = ST_MEAN;
                  end
               end
            end
         end
         ST_MEAN: begin
            if (div_done) begin
               // Floor division: round negative quotients toward minus infinity.
               if (neg_ff) begin
                  mean_in = -signed'(q_mean + (DW+1)'(div_rem != '0));
               end else begin
                  mean_in = signed'(q_mean);
               end
               idx_in   = '0;
               ss_in    = '0;
               state_in = ST_VRD;
            end
         end
         ST_VRD: state_in = ST_VD;
         ST_VD: begin
            mag_in   = dev[DW+1] ? DW'(-dev) : DW'(dev);
            state_in = ST_VM0;
         end
         ST_VM0: state_in = ST_VM1;
         ST_VM1: begin
            sq_in    = {prod_ff, 32'b0};
            state_in = ST_VM2;
         end
         ST_VM2: begin
            sq_in    = sq_ff + {15'b0, prod_ff, 17'b0};
            state_in = ST_VA1;
         end
         ST_VA1: begin
            sq_in    = sq_ff + 64'(prod_ff);
            state_in = ST_VA2;
         end
         ST_VA2: begin
            ss_in = ss_ff + (sq_ff >> 6);
            if (CW'(idx_ff) == n_last) begin
               state_in = ST_VDIV;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_VRD;
            end
         end
         ST_VDIV: begin
            if (div_done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               csp_in   = 48'(sigma_ff * root);
               state_in = ST_SCL;
            end
         end
         ST_SCL: begin
            // Offset = mean - c * stdev; stdev carries three fraction bits fewer than
            // Q16.16 and c has twelve, so the product drops nine.
            offset_in = 42'(mean_ff) - 42'(csp_ff >> 9);
            idx_in    = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            pend_in      = 1'b1;
            pend_idx_in  = idx_ff;
            pend_last_in = (CW'(idx_ff) == n_last);
            idx_in       = idx_ff + 1'b1;
            if (CW'(idx_ff) == n_last) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sigma_ff     <= stf_pkg::SIGMA_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         offs_go_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         sigma_ff     <= sigma_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= pend_ff;
         offs_go_ff   <= offs_go_in;
      end
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      neg_ff       <= neg_in;
      mean_ff      <= mean_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      sq_ff        <= sq_in;
      ss_ff        <= ss_in;
      csp_ff       <= csp_in;
      offset_ff    <= offset_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   stf_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_POPULATION)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (req_payload.fitness),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   stf_div #(
      .DW (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   stf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quo),
      .done     (sqrt_done),
      .root     (root)
   );

   assign busy        = (state_ff != ST_LOAD) || offs_go_ff;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The last result of a run is never directly followed by another.
   `STF_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_payload.last_out, !rsp_valid)
   // The RAM is only written while loading.
   `STF_ASSERT_IMPLIES(a_ram_quiet, clock, reset, ram_we, state_ff == ST_LOAD)
   // Every result comes from a RAM read issued in the emit pass.
   `STF_ASSERT_IMPLIES(a_rsp_src, clock, reset, pend_ff, $past(state_ff) == ST_EMIT)

endmodule

// ===== design/stf_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// Standalone; no package dependencies.
module stf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/stf_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on stf_pkg for the dividend width.
module stf_div #(
   parameter int DW = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [stf_pkg::DIV_W-1:0] dividend,
   input  logic [DW-1:0]             divisor,
   output logic                      done,
   output logic [stf_pkg::DIV_W-1:0] quotient,
   output logic [DW-1:0]             remainder
);

   logic [stf_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [DW-1:0]                 rem_ff, rem_in, dvs_ff, dvs_in;
   logic [stf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in, done_ff, done_in;
   logic [DW:0]                   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[stf_pkg::DIV_W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[stf_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[stf_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == stf_pkg::DIV_CNT_W'(stf_pkg::DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/stf_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on stf_pkg for operand and root widths.
module stf_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [stf_pkg::DIV_W-1:0]  radicand,
   output logic                       done,
   output logic [stf_pkg::ROOT_W-1:0] root
);

   logic [stf_pkg::DIV_W-1:0]      val_ff, val_in;
   logic [stf_pkg::ROOT_W+1:0]     rem_ff, rem_in;
   logic [stf_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [stf_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           run_ff, run_in, done_ff, done_in;
   logic [stf_pkg::ROOT_W+3:0]     part, trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      part    = {rem_ff, val_ff[stf_pkg::DIV_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         val_in = {val_ff[stf_pkg::DIV_W-3:0], 2'b00};
         if (part >= trial) begin
            rem_in  = (stf_pkg::ROOT_W + 2)'(part - trial);
            root_in = {root_ff[stf_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = part[stf_pkg::ROOT_W+1:0];
            root_in = {root_ff[stf_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the sigma truncation fitness scaler: populations of Q16.16 fitness values in,
// scaled results out, checked against a predictor of mean, sample stdev and truncation.
// Depends on stf_pkg and the sigma_truncation_fitness_scaler top level.
`timescale 1ns / 100ps

module tb_top;

   localparam int POP_MAX     = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 400;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   stf_pkg::req_type          req_payload;
   logic                      rsp_valid;
   stf_pkg::rsp_type          rsp_payload;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [stf_pkg::CSR_W-1:0] csr_data;

   sigma_truncation_fitness_scaler #(.MAX_POPULATION(POP_MAX)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Predictor state, a private copy of what the block holds.
   logic signed [31:0] pop_values [POP_MAX];
   int                 pop_size;
   logic [15:0]        multiplier_c;

   stf_pkg::req_type item_queue [$];
   stf_pkg::rsp_type scaled_queue [$];
   int      mismatch_count;
   int      cycle_count;
   int      gap_left;
   bit      hold_sender;
   // Value of busy at the last rising edge, before that edge took effect.
   logic    busy_seen;

   function automatic longint floor_divide(longint num, longint den);
      if (num >= 0) begin
         return num / den;
      end
      return -((-num + den - 1) / den);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v = v - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   // Applies one accepted transaction to the predictor and queues any results it produces.
   task automatic predict_scaled(input stf_pkg::req_type item);
      longint            total;
      longint            mean;
      longint            offset;
      longint            dev;
      longint            val;
      longint unsigned   mag;
      longint unsigned   sq_sum;
      longint unsigned   stdev;
      longint unsigned   c_stdev;
      stf_pkg::rsp_type  r;
      int                n;
      if (pop_size < POP_MAX) begin
         pop_values[pop_size] = item.fitness;
         pop_size++;
      end
      if (!item.is_last) return;
      n = pop_size;
      pop_size = 0;
      if (n == 0) return;
      total = 0;
      for (int i = 0; i < n; i++) total += longint'(pop_values[i]);
      mean = floor_divide(total, n);
      stdev = 0;
      if (n > 1) begin
         sq_sum = 0;
         for (int i = 0; i < n; i++) begin
            dev = longint'(pop_values[i]) - mean;
            mag = (dev < 0) ? -dev : dev;
            sq_sum += (mag * mag) >> 6;
         end
         stdev = int_sqrt(sq_sum / longint'(n - 1)) << 3;
      end
      c_stdev = (longint'(multiplier_c) * stdev) >> 12;
      offset = mean - longint'(c_stdev);
      for (int i = 0; i < n; i++) begin
         val = longint'(pop_values[i]) - offset;
         if (val < 0) val = 0;
         if (val > 64'h7FFFFFFF) val = 64'h7FFFFFFF;
         r.scaled_fitness = val[30:0];
         r.member_index   = i[5:0];
         r.last_out       = (i == n - 1);
         scaled_queue.push_back(r);
      end
   endtask

   // Driver: start and the payload change on the falling edge only, one assignment per step.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy_seen) begin
            // The transaction was taken at the last rising edge.
            predict_scaled(req_payload);
            void'(item_queue.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (hold_sender || item_queue.size() == 0) begin
            start <= 1'b0;
         end else begin
            req_payload <= item_queue[0];
            start <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(1, 3);
            end
         end
      end
   end

   // Monitor: results are sampled at the rising edge that ends their strobe cycle.
   always @(posedge clock) begin
      cycle_count++;
      busy_seen <= busy;
      if (!reset && rsp_valid) begin
         if (scaled_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: %h", rsp_payload);
         end else if (rsp_payload !== scaled_queue[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected fit=%h idx=%0d last=%b, got fit=%h idx=%0d last=%b",
                        scaled_queue[0].scaled_fitness, scaled_queue[0].member_index,
                        scaled_queue[0].last_out, rsp_payload.scaled_fitness,
                        rsp_payload.member_index, rsp_payload.last_out);
            void'(scaled_queue.pop_front());
         end else begin
            void'(scaled_queue.pop_front());
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_item(input logic signed [31:0] value, input logic last);
      stf_pkg::req_type item;
      item.fitness = value;
      item.is_last = last;
      item_queue.push_back(item);
   endtask

   // Waits until every queued transaction is taken and every result has come.
   task automatic drain_all();
      while (item_queue.size() != 0 || scaled_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_multiplier(input logic [15:0] value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      multiplier_c = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random population; values are mostly clustered so the truncation is meaningful,
   // occasionally full range so saturation and clamping appear.
   task automatic add_population(input int size);
      logic signed [31:0] center;
      logic signed [31:0] v;
      int                 spread;
      center = $urandom();
      spread = 1 << $urandom_range(4, 24);
      for (int i = 0; i < size; i++) begin
         if ($urandom_range(0, 4) == 0) v = $urandom();
         else v = center + $signed($urandom_range(0, 2 * spread)) - spread;
         add_item(v, i == size - 1);
      end
   endtask

   initial begin
      int pick;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      mismatch_count = 0;
      cycle_count = 0;
      gap_left = 0;
      hold_sender = 1'b0;
      pop_size = 0;
      multiplier_c = stf_pkg::SIGMA_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single member, field extremes, a population of identical values and an alternating-bit pair.
      add_item(32'sd12345, 1'b1);
      add_item(32'h7FFFFFFF, 1'b0);
      add_item(32'h80000000, 1'b1);
      add_item(32'h7FFFFFFF, 1'b0);
      add_item(32'h00000000, 1'b0);
      add_item(32'hFFFFFFFF, 1'b0);
      add_item(32'h80000000, 1'b1);
      for (int i = 0; i < 4; i++) add_item(32'h00010000, i == 3);
      add_item(32'h55555555, 1'b0);
      add_item(32'hAAAAAAAA, 1'b1);
      drain_all();

      // Over capacity: the excess values are dropped, the last flag still ends the run.
      write_multiplier(16'd0);
      for (int i = 0; i < POP_MAX + 3; i++)
         add_item($urandom(), i == POP_MAX + 2);
      drain_all();

      write_multiplier(16'hFFFF);
      add_population(16);
      drain_all();

      // Random phases, each under a different multiplier setting.
      for (int phase = 0; phase < 6; phase++) begin
         write_multiplier((phase == 0) ? 16'd4096 : 16'($urandom()));
         for (int p = 0; p < 2; p++) begin
            pick = $urandom_range(0, 9);
            add_population(pick == 0 ? $urandom_range(9, 16) : $urandom_range(1, 6));
         end
         if (phase == 2) begin
            // Sender holds off until the block has delivered every expected result.
            while (item_queue.size() != 0) @(posedge clock);
            hold_sender = 1'b1;
            while (scaled_queue.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain_all();
      end
      write_multiplier(stf_pkg::SIGMA_RESET);
      add_population(5);
      drain_all();

      if (mismatch_count == 0 && scaled_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
